@@ design/r2h_pkg.sv @@
// r2h_pkg: shared constants and types for the RGB to HSL converter.
// No dependencies; used by the interfaces and the top level.
package r2h_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CH_W      = 17;
  localparam int HUE_W     = 16;
  localparam int DIV_STEPS = 17;

  localparam logic [CH_W-1:0] ONE        = CH_W'(1) << FRAC_BITS;
  localparam logic [CH_W-1:0] GRAY_RESET = CH_W'(66);

  // floor(x/6) = (x * RECIP_K) >> RECIP_SH for x < 2^19
  localparam int              RECIP_SH = 24;
  localparam logic [21:0]     RECIP_K  = 22'd2796203;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

endpackage

@@ design/r2h_if.sv @@
// r2h_if: valid/ready channels for RGB pixels in and HSL pixels out.
// Depends on r2h_pkg for channel widths.
interface r2h_rgb_if;
  logic                      valid;
  logic                      ready;
  logic [r2h_pkg::CH_W-1:0]  red_in;
  logic [r2h_pkg::CH_W-1:0]  green_in;
  logic [r2h_pkg::CH_W-1:0]  blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface r2h_hsl_if;
  logic                      valid;
  logic                      ready;
  logic [r2h_pkg::HUE_W-1:0] hue_out;
  logic [r2h_pkg::CH_W-1:0]  saturation_out;
  logic [r2h_pkg::CH_W-1:0]  luminance_out;

  modport source (output valid, hue_out, saturation_out, luminance_out, input ready);
  modport sink   (input valid, hue_out, saturation_out, luminance_out, output ready);
endinterface

@@ design/rgb_to_hsl_converter_unit.sv @@
// rgb_to_hsl_converter_unit: streaming RGB to HSL conversion, fixed point.
// Depends on r2h_pkg and the channel interfaces in r2h_if.sv.
//
// Accepts one pixel beat per clock while not stalled and returns one HSL beat per
// pixel, in order, through an input register, a front stage (max/min, sector,
// divisor select), two 17-stage restoring dividers running side by side (one
// quotient bit per stage, for saturation and hue), a hue sum stage, a multiply
// by the reciprocal of 6 and the output register. The whole pipeline advances
// whenever the output register is empty or being taken, so a stall freezes every
// stage. gray_threshold is written through cfg_wr_en/cfg_wr_data and resets to 66.
module rgb_to_hsl_converter_unit (
  input  logic                      clk,
  input  logic                      rst,
  r2h_rgb_if.sink                   pixel_rgb,
  r2h_hsl_if.source                 pixel_hsl,
  input  logic                      cfg_wr_en,
  input  logic [r2h_pkg::CH_W-1:0]  cfg_wr_data
);

  localparam int N = r2h_pkg::DIV_STEPS;
  localparam int W = r2h_pkg::CH_W;

  logic         en;
  logic [W-1:0] gray_threshold;

  assign en              = !pixel_hsl.valid || pixel_hsl.ready;
  assign pixel_rgb.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_threshold <= r2h_pkg::GRAY_RESET;
    end else if (cfg_wr_en) begin
      gray_threshold <= cfg_wr_data;
    end
  end

  // input register
  logic         in_vld;
  logic [W-1:0] in_r, in_g, in_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= pixel_rgb.valid;
    end
    if (en) begin
      in_r <= pixel_rgb.red_in;
      in_g <= pixel_rgb.green_in;
      in_b <= pixel_rgb.blue_in;
    end
  end

  // front stage
  r2h_pkg::sector_t   f_sec;
  logic [W-1:0]       f_mx, f_mn, f_diff, f_lum, f_sden;
  logic [W:0]         f_sum, f_num, f_nabs;
  logic signed [W+1:0] f_den2;
  logic               f_gray, f_lo, f_sat_of, f_zero;

  always_comb begin
    if (in_r >= in_g && in_r >= in_b) begin
      f_sec = r2h_pkg::SEC_RED;
      f_mx  = in_r;
      f_num = {1'b0, in_g} - {1'b0, in_b};
    end else if (in_g >= in_b) begin
      f_sec = r2h_pkg::SEC_GREEN;
      f_mx  = in_g;
      f_num = {1'b0, in_b} - {1'b0, in_r};
    end else begin
      f_sec = r2h_pkg::SEC_BLUE;
      f_mx  = in_b;
      f_num = {1'b0, in_r} - {1'b0, in_g};
    end
    f_mn = in_r;
    if (in_g < f_mn) f_mn = in_g;
    if (in_b < f_mn) f_mn = in_b;
    f_diff   = f_mx - f_mn;
    f_sum    = {1'b0, f_mx} + {1'b0, f_mn};
    f_gray   = f_diff < gray_threshold;
    f_lum    = f_gray ? in_r : f_sum[W:1];
    f_zero   = f_gray || (f_diff == '0);
    f_lo     = f_sum < {1'b0, r2h_pkg::ONE};
    f_den2   = $signed({1'b0, r2h_pkg::ONE, 1'b0}) - $signed({1'b0, f_sum});
    f_sden   = f_lo ? f_sum[W-1:0] : f_den2[W-1:0];
    f_sat_of = (!f_lo && (f_den2 <= 0)) || ({1'b0, f_diff} >= {f_sden, 1'b0});
    f_nabs   = f_num[W] ? (~f_num + 1'b1) : f_num;
  end

  // divider pipeline, index 0 is the front register
  logic             d_vld    [0:N];
  logic [W:0]       d_srem   [0:N];
  logic [W-1:0]     d_sden   [0:N];
  logic [W-1:0]     d_sq     [0:N];
  logic [W:0]       d_hrem   [0:N];
  logic [W-1:0]     d_hden   [0:N];
  logic [W-1:0]     d_hq     [0:N];
  logic [W-1:0]     d_lum    [0:N];
  logic             d_zero   [0:N];
  logic             d_sat_of [0:N];
  logic             d_neg    [0:N];
  r2h_pkg::sector_t d_sec    [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld[0] <= 1'b0;
    end else if (en) begin
      d_vld[0] <= in_vld;
    end
    if (en) begin
      d_srem[0]   <= {1'b0, f_diff};
      d_sden[0]   <= f_sden;
      d_sq[0]     <= '0;
      d_hrem[0]   <= f_nabs;
      d_hden[0]   <= f_diff;
      d_hq[0]     <= '0;
      d_lum[0]    <= f_lum;
      d_zero[0]   <= f_zero;
      d_sat_of[0] <= f_sat_of;
      d_neg[0]    <= f_num[W];
      d_sec[0]    <= f_sec;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_div
    logic       s_ge, h_ge;
    logic [W:0] s_t, h_t;

    always_comb begin
      s_ge = d_srem[k-1] >= {1'b0, d_sden[k-1]};
      s_t  = s_ge ? d_srem[k-1] - {1'b0, d_sden[k-1]} : d_srem[k-1];
      h_ge = d_hrem[k-1] >= {1'b0, d_hden[k-1]};
      h_t  = h_ge ? d_hrem[k-1] - {1'b0, d_hden[k-1]} : d_hrem[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[k] <= 1'b0;
      end else if (en) begin
        d_vld[k] <= d_vld[k-1];
      end
      if (en) begin
        d_srem[k]   <= {s_t[W-1:0], 1'b0};
        d_sden[k]   <= d_sden[k-1];
        d_sq[k]     <= {d_sq[k-1][W-2:0], s_ge};
        d_hrem[k]   <= {h_t[W-1:0], 1'b0};
        d_hden[k]   <= d_hden[k-1];
        d_hq[k]     <= {d_hq[k-1][W-2:0], h_ge};
        d_lum[k]    <= d_lum[k-1];
        d_zero[k]   <= d_zero[k-1];
        d_sat_of[k] <= d_sat_of[k-1];
        d_neg[k]    <= d_neg[k-1];
        d_sec[k]    <= d_sec[k-1];
      end
    end
  end

  // hue sum stage
  logic signed [W+2:0] e_h6, e_base, e_off;
  logic [W+1:0]        e_habs;
  logic [W-1:0]        e_sat;

  always_comb begin
    case (d_sec[N])
      r2h_pkg::SEC_GREEN: e_base = $signed({3'b0, r2h_pkg::ONE} << 1);
      r2h_pkg::SEC_BLUE:  e_base = $signed({3'b0, r2h_pkg::ONE} << 2);
      default:            e_base = '0;
    endcase
    e_off  = d_neg[N] ? -$signed({3'b0, d_hq[N]}) : $signed({3'b0, d_hq[N]});
    e_h6   = e_base + e_off;
    e_habs = e_h6[W+2] ? W'(0) + (W+2)'(-e_h6) : (W+2)'(e_h6);
    if (d_zero[N]) begin
      e_sat = '0;
    end else if (d_sat_of[N] || d_sq[N] > r2h_pkg::ONE) begin
      e_sat = r2h_pkg::ONE;
    end else begin
      e_sat = d_sq[N];
    end
  end

  logic         e1_vld, e1_neg, e1_zero;
  logic [W+1:0] e1_habs;
  logic [W-1:0] e1_sat, e1_lum;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_vld <= 1'b0;
    end else if (en) begin
      e1_vld <= d_vld[N];
    end
    if (en) begin
      e1_neg  <= e_h6[W+2];
      e1_zero <= d_zero[N];
      e1_habs <= e_habs;
      e1_sat  <= e_sat;
      e1_lum  <= d_lum[N];
    end
  end

  // multiply by the reciprocal of 6
  logic         e2_vld, e2_neg, e2_zero;
  logic [40:0]  e2_prod;
  logic [W-1:0] e2_sat, e2_lum;

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_vld <= 1'b0;
    end else if (en) begin
      e2_vld <= e1_vld;
    end
    if (en) begin
      e2_prod <= 41'(e1_habs) * 41'(r2h_pkg::RECIP_K);
      e2_neg  <= e1_neg;
      e2_zero <= e1_zero;
      e2_sat  <= e1_sat;
      e2_lum  <= e1_lum;
    end
  end

  // output register
  logic [W-1:0]              o_q6;
  logic [r2h_pkg::HUE_W-1:0] o_hue;

  always_comb begin
    o_q6 = e2_prod[r2h_pkg::RECIP_SH +: W];
    if (e2_zero) begin
      o_hue = '0;
    end else if (e2_neg) begin
      o_hue = r2h_pkg::HUE_W'(~o_q6 + 1'b1);
    end else begin
      o_hue = o_q6[r2h_pkg::HUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_hsl.valid <= 1'b0;
    end else if (en) begin
      pixel_hsl.valid <= e2_vld;
    end
    if (en) begin
      pixel_hsl.hue_out        <= o_hue;
      pixel_hsl.saturation_out <= e2_sat;
      pixel_hsl.luminance_out  <= e2_lum;
    end
  end

`ifndef SYNTHESIS
  a_sat_cap: assert property (@(posedge clk) disable iff (rst)
    pixel_hsl.valid |-> pixel_hsl.saturation_out <= r2h_pkg::ONE)
    else $error("saturation above 1.0");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (pixel_rgb.valid && pixel_rgb.ready) |=> in_vld)
    else $error("accepted beat lost at input register");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (pixel_hsl.valid && !pixel_hsl.ready) |=> $stable(d_vld[N]) && $stable(e1_vld))
    else $error("pipeline moved during stall");
`endif

endmodule

@@ tb/r2h_tb_if.sv @@
`timescale 1ns / 1ps
// Testbench-side note: the block's channel interfaces come from design/r2h_if.sv.
// This file holds a shared beat struct used by the checker.
// Depends on r2h_pkg.
package r2h_tb_pkg;

  typedef struct packed {
    logic [r2h_pkg::HUE_W-1:0] hue;
    logic [r2h_pkg::CH_W-1:0]  sat;
    logic [r2h_pkg::CH_W-1:0]  lum;
  } hsl_beat_t;
endpackage

@@ tb/r2h_checker.sv @@
`timescale 1ns / 1ps
// r2h_checker: watches the RGB and HSL channels, predicts each HSL beat and
// compares it with the block's output. Depends on r2h_pkg and r2h_tb_pkg.
module r2h_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rgb_valid,
  input  logic                      rgb_ready,
  input  logic [r2h_pkg::CH_W-1:0]  red,
  input  logic [r2h_pkg::CH_W-1:0]  green,
  input  logic [r2h_pkg::CH_W-1:0]  blue,
  input  logic                      hsl_valid,
  input  logic                      hsl_ready,
  input  logic [r2h_pkg::HUE_W-1:0] hue,
  input  logic [r2h_pkg::CH_W-1:0]  sat,
  input  logic [r2h_pkg::CH_W-1:0]  lum,
  input  logic                      cfg_wr_en,
  input  logic [r2h_pkg::CH_W-1:0]  cfg_wr_data,
  output int                        fail_count,
  output int                        pending
);

  r2h_tb_pkg::hsl_beat_t      hsl_expected_q[$];
  logic [r2h_pkg::CH_W-1:0]   gray_level;
  int                         mismatches = 0;

  function automatic longint clamp_ratio(longint num, longint den);
    longint q;
    if (den <= 0) return longint'(r2h_pkg::ONE);
    q = (num * longint'(r2h_pkg::ONE)) / den;
    return (q > longint'(r2h_pkg::ONE)) ? longint'(r2h_pkg::ONE) : q;
  endfunction

  function automatic r2h_tb_pkg::hsl_beat_t convert_pixel(
      logic [r2h_pkg::CH_W-1:0] r_v, logic [r2h_pkg::CH_W-1:0] g_v,
      logic [r2h_pkg::CH_W-1:0] b_v, logic [r2h_pkg::CH_W-1:0] thr);
    longint r, g, b, mx, mn, diff, sum, l, s, h, num, base, one;
    r2h_tb_pkg::hsl_beat_t o;
    one = longint'(r2h_pkg::ONE);
    r = r_v; g = g_v; b = b_v;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    diff = mx - mn;
    sum = mx + mn;
    if (diff < longint'(thr)) begin
      o.hue = '0;
      o.sat = '0;
      o.lum = r_v;
      return o;
    end
    l = sum / 2;
    if (diff == 0) begin
      s = 0;
      h = 0;
    end else begin
      if (l < one / 2) s = clamp_ratio(diff, sum);
      else s = clamp_ratio(diff, 2 * one - sum);
      if (mx == r) begin
        base = 0; num = g - b;
      end else if (mx == g) begin
        base = 2 * one; num = b - r;
      end else begin
        base = 4 * one; num = r - g;
      end
      h = (base + (num * one) / diff) / 6;
      if (h < 0) h += one;
    end
    o.hue = r2h_pkg::HUE_W'(h & (one - 1));
    o.sat = r2h_pkg::CH_W'(s);
    o.lum = r2h_pkg::CH_W'(l);
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  assign pending    = hsl_expected_q.size();
  assign fail_count = mismatches;

  always @(posedge clk) begin
    r2h_tb_pkg::hsl_beat_t want;
    if (rst) begin
      gray_level <= r2h_pkg::GRAY_RESET;
    end else begin
      if (cfg_wr_en) gray_level <= cfg_wr_data;
      if (rgb_valid && rgb_ready)
        hsl_expected_q.push_back(convert_pixel(red, green, blue, gray_level));
      if (hsl_valid && hsl_ready) begin
        if (hsl_expected_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          want = hsl_expected_q.pop_front();
          if (hue !== want.hue) report_mismatch("hue", hue, want.hue);
          if (sat !== want.sat) report_mismatch("saturation", sat, want.sat);
          if (lum !== want.lum) report_mismatch("luminance", lum, want.lum);
        end
      end
    end
  end

endmodule

@@ tb/rgb_to_hsl_converter_unit_tb.sv @@
`timescale 1ns / 1ps
// rgb_to_hsl_converter_unit_tb: drives pixels and threshold settings with random
// gaps and stalls. Depends on r2h_pkg, r2h_if, r2h_checker and the block.
module rgb_to_hsl_converter_unit_tb;

  localparam int LATENCY = 22;

  logic                     clk = 0;
  logic                     rst = 1;
  logic                     cfg_wr_en = 0;
  logic [r2h_pkg::CH_W-1:0] cfg_wr_data = '0;
  int                       fail_count;
  int                       pending;
  bit                       long_hold = 0;
  bit                       stim_done = 0;

  r2h_rgb_if pixel_rgb();
  r2h_hsl_if pixel_hsl();

  initial begin
    pixel_rgb.valid = 0;
    pixel_rgb.red_in = '0;
    pixel_rgb.green_in = '0;
    pixel_rgb.blue_in = '0;
    pixel_hsl.ready = 0;
  end

  rgb_to_hsl_converter_unit DUT (
    .clk(clk), .rst(rst), .pixel_rgb(pixel_rgb), .pixel_hsl(pixel_hsl),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  r2h_checker checker_i (
    .clk(clk), .rst(rst),
    .rgb_valid(pixel_rgb.valid), .rgb_ready(pixel_rgb.ready),
    .red(pixel_rgb.red_in), .green(pixel_rgb.green_in), .blue(pixel_rgb.blue_in),
    .hsl_valid(pixel_hsl.valid), .hsl_ready(pixel_hsl.ready),
    .hue(pixel_hsl.hue_out), .sat(pixel_hsl.saturation_out),
    .lum(pixel_hsl.luminance_out),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [r2h_pkg::CH_W-1:0] rand_channel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return r2h_pkg::ONE;
      2: return r2h_pkg::CH_W'($urandom_range(r2h_pkg::ONE, (1 << r2h_pkg::CH_W) - 1));
      3: return r2h_pkg::CH_W'($urandom_range(0, 200));
      default: return r2h_pkg::CH_W'($urandom_range(0, r2h_pkg::ONE));
    endcase
  endfunction

  task automatic send_pixel(logic [r2h_pkg::CH_W-1:0] r, logic [r2h_pkg::CH_W-1:0] g,
                            logic [r2h_pkg::CH_W-1:0] b, bit no_gap);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14));
    if (gap > 0) begin
      pixel_rgb.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    pixel_rgb.valid <= 1;
    pixel_rgb.red_in <= r;
    pixel_rgb.green_in <= g;
    pixel_rgb.blue_in <= b;
    @(posedge clk);
    while (!pixel_rgb.ready) @(posedge clk);
  endtask

  task automatic drain_and_write(logic [r2h_pkg::CH_W-1:0] thr);
    pixel_rgb.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  // Receiver: random stalls per beat, plus one long hold-off.
  initial begin
    int stall;
    bit hold_done;
    hold_done = 0;
    @(negedge rst);
    forever begin
      if (long_hold && !hold_done) begin
        pixel_hsl.ready <= 0;
        repeat (300) @(posedge clk);
        hold_done = 1;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (stim_done || $urandom_range(0, 4) == 0) stall = 0;
      if (stall > 0) begin
        pixel_hsl.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      pixel_hsl.ready <= 1;
      @(posedge clk);
      while (!pixel_hsl.valid) @(posedge clk);
    end
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [r2h_pkg::CH_W-1:0] thr_set[5];
    logic [r2h_pkg::CH_W-1:0] r, g, b;
    thr_set = '{r2h_pkg::CH_W'(0), r2h_pkg::CH_W'(1), r2h_pkg::ONE, r2h_pkg::CH_W'(1000),
                r2h_pkg::CH_W'((1 << r2h_pkg::CH_W) - 1)};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset threshold
    send_pixel('0, '0, '0, 0);
    send_pixel(r2h_pkg::ONE, r2h_pkg::ONE, r2h_pkg::ONE, 0);
    send_pixel(r2h_pkg::ONE, '0, '0, 0);
    send_pixel('0, r2h_pkg::ONE, '0, 0);
    send_pixel('0, '0, r2h_pkg::ONE, 0);
    send_pixel(r2h_pkg::ONE, r2h_pkg::ONE, '0, 0);
    send_pixel('0, r2h_pkg::ONE, r2h_pkg::ONE, 0);
    send_pixel(r2h_pkg::ONE, '0, r2h_pkg::ONE, 0);
    send_pixel(r2h_pkg::CH_W'(100), r2h_pkg::CH_W'(100 + 65), r2h_pkg::CH_W'(100), 0);
    send_pixel(r2h_pkg::CH_W'(100), r2h_pkg::CH_W'(100 + 66), r2h_pkg::CH_W'(100), 0);
    send_pixel(r2h_pkg::CH_W'(40000), r2h_pkg::CH_W'(10000), r2h_pkg::CH_W'(20000), 0);
    send_pixel(r2h_pkg::CH_W'(30000), r2h_pkg::CH_W'(35000), r2h_pkg::CH_W'(32767), 0);
    send_pixel(r2h_pkg::CH_W'(32768), r2h_pkg::CH_W'(32768), r2h_pkg::CH_W'(0), 0);
    send_pixel('1, '1, '0, 0);
    send_pixel('1, r2h_pkg::CH_W'(70000), r2h_pkg::CH_W'(66000), 0);
    send_pixel(r2h_pkg::CH_W'(100000), r2h_pkg::CH_W'(20000), r2h_pkg::CH_W'(100000), 0);
    send_pixel(r2h_pkg::CH_W'(5), r2h_pkg::CH_W'(0), r2h_pkg::CH_W'(5), 0);
    drain_and_write('0);
    send_pixel(r2h_pkg::CH_W'(1234), r2h_pkg::CH_W'(1234), r2h_pkg::CH_W'(1234), 0);
    send_pixel('1, '1, '1, 0);
    send_pixel(r2h_pkg::CH_W'(7), r2h_pkg::CH_W'(8), r2h_pkg::CH_W'(7), 0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) drain_and_write(ph == 5 ? r2h_pkg::GRAY_RESET : thr_set[ph]);
      for (int i = 0; i < 240; i++) begin
        r = rand_channel(); g = rand_channel(); b = rand_channel();
        if ($urandom_range(0, 9) == 0) begin
          g = r; b = r;
        end
        if (ph == 2 && i == 100) begin
          long_hold = 1;
          for (int k = 0; k < 60; k++) send_pixel(r ^ r2h_pkg::CH_W'(k), g, b, 1);
        end else begin
          send_pixel(r, g, b, ph == 4 && i < 60);
        end
      end
    end

    pixel_rgb.valid <= 0;
    stim_done = 1;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ rgb_to_hsl_converter_unit.f @@
design/r2h_pkg.sv
design/r2h_if.sv
design/rgb_to_hsl_converter_unit.sv
tb/r2h_tb_if.sv
tb/r2h_checker.sv
tb/rgb_to_hsl_converter_unit_tb.sv
